/* design/assert_macros.svh */
// Assertion macros shared by the RTL of the masked key search block.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge, suspended while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* design/mkbs_pkg.sv */
// Package of the masked key binary search block: codes, field widths and defaults.
// Used by masked_key_binary_search; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mkbs_pkg;

  // Default table depth and field widths.
  localparam int unsigned MKBS_TABLE_DEPTH = 256;
  localparam int unsigned KEY_W            = 32;
  localparam int unsigned SLOT_W           = 8;
  localparam int unsigned COUNT_W          = 9;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned CFG_DATA_W       = 32;

  localparam logic [KEY_W-1:0] RESET_KEY_MASK = 32'hFFFF_FF00;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT = 1'b0,
    REG_KEY_MASK    = 1'b1
  } cfg_reg_t;

  // Kinds of input word.
  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_LOOKUP = 1'b1
  } item_kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_DONE  = 3'b100
  } seq_state_t;

endpackage

`default_nettype wire

/* design/masked_key_binary_search.sv */
// Top level of the masked key binary search block: key table memory and search sequencer.
// Depends on mkbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// The block holds a table of TABLE_DEPTH 32-bit keys in one synchronous
// memory with a registered read port. A load word (kind 0) writes one slot
// in the cycle it is accepted and produces no result; the next word may
// follow at once. A lookup word (kind 1) masks its key with key_mask and
// binary-searches slots 0 to entry_count-1, where entry_count is clipped to
// TABLE_DEPTH. Each search step is one memory read: the first address is
// issued in the accept cycle, and every following cycle compares the returned
// key and, from precomputed candidates, issues the next address. A lookup
// takes at most ceil(log2(count+1)) probes (nine for a full 256-entry
// table) before its result is posted to the output register; a zero key
// or an empty table takes no probe and posts "not found" from the done
// state directly. The sequencer goes back to idle as it loads the result
// into the output register, so a lookup stalls the input until that point
// and a load never stalls it; the lookup is released as soon as
// the output register is free. The sequencer works on one lookup at a time
// and stalls the input while busy. The result sits in an output register, so
// a new word is taken while an earlier result still waits for the consumer;
// a finished lookup waits in its final state only while that register is
// still held. Slots that were never loaded read back as undefined.
// Configuration is written through the cfg_ port, which is always ready, and
// should be changed only while the block is idle.
module masked_key_binary_search
  import mkbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = MKBS_TABLE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // Configuration write channel.
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data,
  // Input word channel.
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   in_kind,
  input  wire [SLOT_W-1:0]      in_entry_index,
  input  wire [KEY_W-1:0]       in_key_value,
  // Result word channel.
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  out_found,
  output logic [SLOT_W-1:0]     out_found_index,
  output logic [KEY_W-1:0]      out_found_key
);

  // AW addresses the table, CW holds a search bound up to TABLE_DEPTH, and XW
  // is wide enough for the input slot, the count register and any address.
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned XW = (AW > SLOT_W) ? AW + 1 : COUNT_W;

  // Configuration registers.
  logic [COUNT_W-1:0] entry_count_r;
  logic [KEY_W-1:0]   key_mask_r;

  // Key table memory with a registered read port.
  logic [KEY_W-1:0] key_table [TABLE_DEPTH];
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data_r;

  // Search state.
  seq_state_t       state_r, state_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    end_r, end_nxt;
  logic [AW-1:0]    mid_r, mid_nxt;
  logic [KEY_W-1:0] pattern_r;

  // Result waiting for the output register.
  logic              res_found_r, res_found_nxt;
  logic [SLOT_W-1:0] res_index_r, res_index_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;

  // Output register.
  logic              out_valid_r;
  logic              out_found_r;
  logic [SLOT_W-1:0] out_found_index_r;
  logic [KEY_W-1:0]  out_found_key_r;

  logic in_acc;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      key_mask_r    <= RESET_KEY_MASK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENTRY_COUNT: entry_count_r <= cfg_data[COUNT_W-1:0];
        REG_KEY_MASK:    key_mask_r    <= cfg_data[KEY_W-1:0];
        default:         ;
      endcase
    end
  end

  // Load slot, range-checked against the table depth.
  logic [XW-1:0] wr_slot_x;
  logic          wr_en;

  assign wr_slot_x = XW'(in_entry_index);
  assign wr_en     = in_acc && (in_kind == KIND_LOAD) && (wr_slot_x < XW'(TABLE_DEPTH));

  // Search end for a new lookup: the entry count clipped to the table depth.
  logic [XW-1:0] count_x;
  logic [CW-1:0] end0;
  logic [CW-1:0] end0_m1;
  logic [AW-1:0] mid0;

  assign count_x = XW'(entry_count_r);
  assign end0    = (count_x > XW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_x[CW-1:0];
  assign end0_m1 = end0 - CW'(1);
  assign mid0    = end0_m1[AW:1];

  // Compare of the returned key and both candidate next probes. The candidate
  // for a lower half is used only when that half is not empty.
  logic [KEY_W-1:0] probe_masked;
  logic             probe_eq;
  logic             probe_gt;
  logic [CW-1:0]    mid_w;
  logic [CW-1:0]    mid_p1;
  logic [CW:0]      sum_lower;
  logic [CW:0]      sum_upper;
  logic [AW-1:0]    mid_lower;
  logic [AW-1:0]    mid_upper;

  assign probe_masked = rd_data_r & key_mask_r;
  assign probe_eq     = (probe_masked == pattern_r);
  assign probe_gt     = (probe_masked > pattern_r);
  assign mid_w        = CW'(mid_r);
  assign mid_p1       = mid_w + CW'(1);
  assign sum_lower    = (CW+1)'(lo_r) + (CW+1)'(mid_r) - (CW+1)'(1);
  assign sum_upper    = (CW+1)'(mid_r) + (CW+1)'(end_r);
  assign mid_lower    = sum_lower[AW:1];
  assign mid_upper    = sum_upper[AW:1];

  logic [XW-1:0] mid_x;
  assign mid_x = XW'(mid_r);

  // The result register may take a new result when it is empty or draining.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    end_nxt       = end_r;
    mid_nxt       = mid_r;
    res_found_nxt = res_found_r;
    res_index_nxt = res_index_r;
    res_key_nxt   = res_key_r;
    rd_addr       = mid_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_LOOKUP)) begin
          res_found_nxt = 1'b0;
          res_index_nxt = '0;
          res_key_nxt   = '0;
          lo_nxt        = '0;
          end_nxt       = end0;
          mid_nxt       = mid0;
          rd_addr       = mid0;
          // A zero key or an empty table skips the search.
          if ((in_key_value == '0) || (end0 == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (probe_eq) begin
          res_found_nxt = 1'b1;
          res_index_nxt = mid_x[SLOT_W-1:0];
          res_key_nxt   = rd_data_r;
          state_nxt     = S_DONE;
        end else if (probe_gt) begin
          end_nxt = mid_w;
          mid_nxt = mid_lower;
          rd_addr = mid_lower;
          if (lo_r >= mid_w) begin
            state_nxt = S_DONE;
          end
        end else begin
          lo_nxt  = mid_p1;
          mid_nxt = mid_upper;
          rd_addr = mid_upper;
          if (mid_p1 >= end_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Table memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_table[wr_slot_x[AW-1:0]] <= in_key_value;
    end
    rd_data_r <= key_table[rd_addr];
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    end_r       <= end_nxt;
    mid_r       <= mid_nxt;
    res_found_r <= res_found_nxt;
    res_index_r <= res_index_nxt;
    res_key_r   <= res_key_nxt;
    if (in_acc) begin
      pattern_r <= in_key_value & key_mask_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r       <= res_found_r;
      out_found_index_r <= res_index_r;
      out_found_key_r   <= res_key_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_found_index = out_found_index_r;
  assign out_found_key   = out_found_key_r;

  // While probing, the search window is never empty and the probe lies in it.
  `ASSERT_CLK(a_window_open, (state_r == S_PROBE) |-> (lo_r < end_r), "empty window in probe")
  `ASSERT_CLK(a_mid_in_window,
              (state_r == S_PROBE) |-> ((mid_w >= lo_r) && (mid_w < end_r)),
              "probe outside search window")
  // A load never starts the sequencer.
  `ASSERT_CLK(a_load_no_search,
              (in_acc && (in_kind == KIND_LOAD)) |=> (state_r == S_IDLE),
              "load started a search")
  // A miss carries zero slot and zero key.
  `ASSERT_CLK(a_miss_zero,
              (out_valid_r && !out_found_r) |->
                ((out_found_index_r == '0) && (out_found_key_r == '0)),
              "miss with nonzero payload")

endmodule

`default_nettype wire

/* dv/tb_masked_key_binary_search.sv */
`timescale 1ns / 1ps
// Self-checking testbench of masked_key_binary_search: table loads, masked
// lookups and register settings, checked against a behavioral table search.
// Depends on mkbs_pkg and the RTL of masked_key_binary_search only.

module tb_masked_key_binary_search;
  import mkbs_pkg::*;

  localparam int unsigned DEPTH        = MKBS_TABLE_DEPTH;
  localparam int unsigned RANDOM_WORDS = 950;
  // A full-table lookup takes at most nine probes, so SETTLE_CYCLES quiet cycles
  // are enough for the block to be idle after the last result word has left.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned PLAN_ROWS     = 27;

  // One lookup outcome, in the order of the result ports.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
  } match_t;

  // The directed plan mixes input words and register writes.
  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_op_t;

  typedef struct packed {
    row_op_t           op;
    item_kind_t        kind;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  value;
    cfg_reg_t          reg_sel;
    logic              typed;
    match_t            want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kind;
  logic [SLOT_W-1:0]     in_entry_index;
  logic [KEY_W-1:0]      in_key_value;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_found;
  logic [SLOT_W-1:0]     out_found_index;
  logic [KEY_W-1:0]      out_found_key;

  // Our own copy of the block's table and registers, updated at the edge at
  // which each word or register write is accepted.
  logic [KEY_W-1:0]   table_copy [DEPTH];
  logic [COUNT_W-1:0] count_copy = '0;
  logic [KEY_W-1:0]   mask_copy  = RESET_KEY_MASK;

  // Outcomes of accepted lookups, oldest first, waiting for their result word.
  match_t expected_matches [$];

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;

  // Sender idling: words go out in bursts with gaps in between, unless the
  // current phase runs the sender flat out.
  int  burst_left = 0;
  bit  flat_out   = 1'b0;

  // Receiver stalling: a stall rate held for a random stretch of cycles.
  int          stall_left = 0;
  int unsigned stall_pct  = 0;

  plan_row_t plan [PLAN_ROWS];

  masked_key_binary_search u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_entry_index  (in_entry_index),
    .in_key_value    (in_key_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_found_index (out_found_index),
    .out_found_key   (out_found_key)
  );

  always #6 clk = ~clk;

  // Binary search over slots 0 to count-1 on masked keys. The count is
  // clipped to the table depth, a zero search key never matches, and the
  // first equal slot met by the probes is the one reported.
  function automatic match_t masked_search(input logic [KEY_W-1:0] key);
    match_t           hit;
    int               lo;
    int               hi;
    int               mid;
    int unsigned      cnt;
    logic [KEY_W-1:0] pattern;
    logic [KEY_W-1:0] probe;
    hit = '0;
    if (key == '0) return hit;
    cnt = (count_copy > DEPTH) ? DEPTH : count_copy;
    pattern = key & mask_copy;
    lo = 0;
    hi = int'(cnt) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      probe = table_copy[mid] & mask_copy;
      if (probe == pattern) begin
        hit.found = 1'b1;
        hit.slot  = mid[SLOT_W-1:0];
        hit.key   = table_copy[mid];
        break;
      end
      if (probe > pattern) hi = mid - 1;
      else lo = mid + 1;
    end
    return hit;
  endfunction

  // Row builders of the directed plan.
  function automatic plan_row_t w_load(input logic [SLOT_W-1:0] slot,
                                       input logic [KEY_W-1:0] key);
    return '{ROW_WORD, KIND_LOAD, slot, key, REG_ENTRY_COUNT, 1'b0, '0};
  endfunction

  // A lookup whose outcome comes from the predictor.
  function automatic plan_row_t w_find(input logic [KEY_W-1:0] key);
    return '{ROW_WORD, KIND_LOOKUP, SLOT_W'($urandom()), key, REG_ENTRY_COUNT, 1'b0, '0};
  endfunction

  // A lookup that must report not found with zero slot and zero key.
  function automatic plan_row_t w_miss(input logic [KEY_W-1:0] key);
    return '{ROW_WORD, KIND_LOOKUP, SLOT_W'($urandom()), key, REG_ENTRY_COUNT, 1'b1, '0};
  endfunction

  function automatic plan_row_t w_cfg(input cfg_reg_t sel, input logic [KEY_W-1:0] data);
    return '{ROW_CFG, KIND_LOAD, '0, data, sel, 1'b0, '0};
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("MISMATCH at %0t ns: %s", $realtime, what);
  endtask

  // Sends one input word and returns at the edge at which it is accepted.
  // Valid is left high, so a following word can go out in the very next
  // cycle; a gap lowers it first.
  task automatic send_word(input item_kind_t kind, input logic [SLOT_W-1:0] slot,
                           input logic [KEY_W-1:0] key, input logic typed,
                           input match_t want);
    if (!flat_out && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= slot;
    in_key_value   <= key;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    words_sent++;
    // A load changes the table at once; the next lookup sees it.
    if (kind == KIND_LOAD) table_copy[slot] = key;
    else expected_matches.push_back(typed ? want : masked_search(key));
  endtask

  // Writes one register. The port should always be ready, but the write
  // still waits for the handshake.
  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (sel == REG_ENTRY_COUNT) count_copy = data[COUNT_W-1:0];
    else mask_copy = data;
    @(posedge clk);
  endtask

  // Holds the sender until every result word has come back, then lets the
  // block settle so that registers can be changed safely.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random phase: new mask and count, a freshly loaded table that is
  // usually sorted on its masked keys, then a run of lookups mixed with a
  // few stray loads.
  task automatic run_phase(input int unsigned phase_no);
    logic [KEY_W-1:0] keys [DEPTH];
    logic [KEY_W-1:0] mask;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] t;
    logic [KEY_W-1:0] count_word;
    int unsigned      cnt;
    int unsigned      fill;
    int unsigned      pick;
    int unsigned      roll;
    int               j;
    case ($urandom_range(0, 5))
      0: mask = '0;
      1: mask = '1;
      2: mask = RESET_KEY_MASK;
      3, 4: mask = '1 << $urandom_range(1, 31);
      default: mask = $urandom();
    endcase
    // The first phase writes the largest count the register holds, which the
    // block must clip to the table depth. Later phases mostly keep tables small.
    roll = $urandom_range(0, 99);
    if (phase_no == 0) cnt = (1 << COUNT_W) - 1;
    else if (roll < 6) cnt = 0;
    else if (roll < 82) cnt = $urandom_range(1, 24);
    else if (roll < 92) cnt = $urandom_range(25, DEPTH - 1);
    else if (roll < 96) cnt = DEPTH;
    else cnt = $urandom_range(DEPTH + 1, (1 << COUNT_W) - 1);
    fill = (cnt > DEPTH) ? DEPTH : cnt;

    // Neighbors often share their masked part, so that several slots match.
    for (int i = 0; i < fill; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0)
        keys[i] = (keys[i-1] & mask) | ($urandom() & ~mask);
      else if ($urandom_range(0, 15) == 0)
        keys[i] = $urandom_range(0, 1) ? '1 : '0;
      else
        keys[i] = $urandom();
    end
    // One phase in ten keeps the table unsorted.
    if ($urandom_range(0, 9) != 0) begin
      for (int i = 1; i < fill; i++) begin
        t = keys[i];
        j = i - 1;
        while (j >= 0 && (keys[j] & mask) > (t & mask)) begin
          keys[j+1] = keys[j];
          j--;
        end
        keys[j+1] = t;
      end
    end

    drain();
    flat_out = ($urandom_range(0, 3) == 0);
    // Bits of the count word above the register width must be ignored.
    count_word = cnt;
    if ($urandom_range(0, 1) == 1) count_word |= $urandom() & ~((1 << COUNT_W) - 1);
    write_reg(REG_ENTRY_COUNT, count_word);
    write_reg(REG_KEY_MASK, mask);

    // Every slot a lookup can probe is loaded before the first lookup.
    for (int i = 0; i < fill; i++) send_word(KIND_LOAD, SLOT_W'(i), keys[i], 1'b0, '0);

    repeat ($urandom_range(8, 40)) begin
      pick = $urandom_range(0, 19);
      t = (fill > 0) ? table_copy[$urandom_range(0, fill - 1)] : $urandom();
      if (pick >= 17) begin
        // Stray load: outside the searched range, or anywhere when the table
        // is full, which may leave it unsorted.
        send_word(KIND_LOAD,
                  SLOT_W'((fill < DEPTH) ? $urandom_range(fill, DEPTH - 1)
                                         : $urandom_range(0, DEPTH - 1)),
                  $urandom(), 1'b0, '0);
      end else begin
        if (pick < 11) k = (t & mask) | ($urandom() & ~mask);
        else if (pick < 13) k = t ^ (32'h1 << $urandom_range(0, 31));
        else if (pick < 14) k = '0;
        else k = $urandom();
        send_word(KIND_LOOKUP, SLOT_W'($urandom()), k, 1'b0, '0);
      end
    end
  endtask

  // Receiver: stalls at a rate, from never to most of the time, that is drawn
  // anew whenever its stretch of cycles runs out.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stall_left--;
      out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end
  end

  // Result checker: each accepted result word is held against the oldest
  // outstanding lookup, one field at a time.
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_matches.size() == 0) begin
        flag_mismatch($sformatf("result word with no lookup pending: found %0d slot %0d key %h",
                                out_found, out_found_index, out_found_key));
      end else begin
        want = expected_matches.pop_front();
        if (out_found !== want.found)
          flag_mismatch($sformatf("found: expected %0d, got %0d", want.found, out_found));
        if (out_found_index !== want.slot)
          flag_mismatch($sformatf("found_index: expected %0d, got %0d",
                                  want.slot, out_found_index));
        if (out_found_key !== want.key)
          flag_mismatch($sformatf("found_key: expected %h, got %h", want.key, out_found_key));
      end
    end
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned random_start;
    int unsigned phase_no;

    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_ENTRY_COUNT;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_kind        <= KIND_LOAD;
    in_entry_index <= '0;
    in_key_value   <= '0;
    foreach (table_copy[i]) table_copy[i] = '0;

    // Directed plan. It starts on the reset settings, where the table is
    // empty, then loads eight sorted slots (two share a masked key) and walks
    // the zero key, masked and exact compares, an unsorted table and a mask
    // of zero, which makes every nonzero key match.
    plan = '{
      w_miss(32'hFFFF_FFFF),
      w_miss(32'h0000_0000),
      w_load(8'd0,   32'h0000_0000),
      w_load(8'd1,   32'h0000_0155),
      w_load(8'd2,   32'h0001_02AA),
      w_load(8'd3,   32'h1000_0000),
      w_load(8'd4,   32'h7FFF_FF7F),
      w_load(8'd5,   32'h8000_0000),
      w_load(8'd6,   32'h8000_00C3),
      w_load(8'd7,   32'hFFFF_FFFF),
      w_load(8'd255, 32'hFFFF_FFFF),
      w_cfg(REG_ENTRY_COUNT, 32'd8),
      w_find(32'h0001_02FF),
      w_miss(32'h0000_0000),
      w_find(32'h0000_0042),
      w_find(32'h8000_0001),
      w_find(32'hFFFF_FFFF),
      w_find(32'h5000_0000),
      w_cfg(REG_KEY_MASK, 32'hFFFF_FFFF),
      w_find(32'h0000_0155),
      w_find(32'h0000_0154),
      w_load(8'd3,   32'hF000_0000),
      w_find(32'h7FFF_FF7F),
      w_find(32'hF000_0000),
      w_cfg(REG_ENTRY_COUNT, 32'd1),
      w_cfg(REG_KEY_MASK, 32'h0000_0000),
      w_find(32'h1234_5678)
    };

    // Synchronous reset, held low and then released.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register writes in the plan wait for the block to go idle first.
    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        drain();
        write_reg(plan[i].reg_sel, plan[i].value);
      end else begin
        send_word(plan[i].kind, plan[i].slot, plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    // Random phases until enough words have gone in. Each phase starts by
    // pausing the sender until every outstanding result word is back.
    random_start = words_sent;
    phase_no = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      run_phase(phase_no);
      phase_no++;
    end

    drain();
    if (mismatches == 0 && expected_matches.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/mkbs_pkg.sv
design/masked_key_binary_search.sv
dv/tb_masked_key_binary_search.sv
